[hdl/hcs_pkg.sv]
// Shared types, codes and constants of the H-bridge command sequencer.
`default_nettype none

package hcs_pkg;

	// Command codes carried by the op field
	typedef enum logic [2:0] {
		OP_RUN_SIGNED  = 3'd0,
		OP_RUN_ONE     = 3'd1,
		OP_STOP_ONE    = 3'd2,
		OP_BRAKE_ONE   = 3'd3,
		OP_RUN_ALL     = 3'd4,
		OP_DIR_ALL     = 3'd5,
		OP_SPEED_ALL   = 3'd6,
		OP_DISABLE_ALL = 3'd7
	} op_t;

	// Published bridge mode
	typedef enum logic [1:0] {
		MODE_COAST = 2'd0,
		MODE_DRIVE = 2'd1,
		MODE_BRAKE = 2'd2
	} mode_t;

	// Direction field codes; anything with the upper bit set is invalid
	localparam logic [1:0] DIR_A = 2'd0;
	localparam logic [1:0] DIR_B = 2'd1;

	localparam int MOTOR_COUNT_DEF = 4;

	// Configuration registers: one PWM period per bridge
	localparam int                 CFG_REG_COUNT = 4;
	localparam int                 CFG_IDX_W     = 2;
	localparam int                 PERIOD_W      = 17;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 17'd1000;

	localparam int PERMILLE_W = 13;
	localparam int COUNT_W    = 32;

	localparam logic [7:0] PCT_MAX   = 8'd100;
	localparam logic [9:0] CMD_LIMIT = 10'd1000;

	// x / 10 as (x * 205) >> 11, exact for x below 1024
	localparam logic [7:0] DIV10_MUL   = 8'd205;
	localparam int         DIV10_SHIFT = 11;

	// x / 100 as (x * ceil(2^31 / 100)) >> 31, exact for x below 2^24
	localparam logic [24:0] DIV100_MUL   = 25'd21474837;
	localparam int          DIV100_SHIFT = 31;

endpackage

`default_nettype wire

[hdl/hcs_if.sv]
// Command and report channel interfaces of the H-bridge command sequencer.
`default_nettype none

interface hcs_cmd_if import hcs_pkg::*; ();
	logic               valid;
	logic               ready;
	op_t                op;
	logic [2:0]         motor;
	logic [1:0]         direction;
	logic [7:0]         percent;
	logic signed [15:0] signed_command;

	modport source (
		output valid, op, motor, direction, percent, signed_command,
		input  ready
	);
	modport sink (
		input  valid, op, motor, direction, percent, signed_command,
		output ready
	);
endinterface

interface hcs_report_if import hcs_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic [2:0]                  motor_index;
	mode_t                       mode;
	logic                        applied_direction;
	logic signed [PERMILLE_W-1:0] applied_permille;
	logic [COUNT_W-1:0]          transition_count;
	logic                        bridge_enable;
	logic [PERIOD_W-1:0]         compare_a;
	logic [PERIOD_W-1:0]         compare_b;
	logic                        last;

	modport source (
		output valid, motor_index, mode, applied_direction, applied_permille,
		       transition_count, bridge_enable, compare_a, compare_b, last,
		input  ready
	);
	modport sink (
		input  valid, motor_index, mode, applied_direction, applied_permille,
		       transition_count, bridge_enable, compare_a, compare_b, last,
		output ready
	);
endinterface

`default_nettype wire

[hdl/hbridge_command_sequencer.sv]
// H-bridge command sequencer: command decode, compare pipeline and report buffer.
//
// Usage:
//   cmd    : valid/ready channel of motor commands (run, stop, brake, all-motor ops).
//   report : valid/ready channel of motor state reports, one per motor that a
//            command touched, in ascending motor order; last marks the final one.
//   cfg_*  : write port for the PWM period of each bridge (index 0..3); write
//            it only while no command is in flight.
// Path: a command passes stages s1, s2 and s3 and is then loaded into the
//   report buffer, from which its first report can be taken.
// Throughput: the report buffer holds the reports of one command (up to MOTOR_COUNT)
//   and drains one per cycle while report.ready is high. Commands that produce no
//   report pass at one per cycle unless a command ahead waits for the buffer.
//   Commands keep flowing into the three front stages while reports drain.
// Reset: all bridges coast in direction A with zero transition counts and all
//   periods at 1000; commands are taken from the first cycle after reset.
// Stall: when report is not taken, the buffer holds its entry, the front stages
//   fill up and then cmd.ready drops; nothing is lost or repeated.
`default_nettype none

module hbridge_command_sequencer import hcs_pkg::*; #(
	parameter int MOTOR_COUNT = MOTOR_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	hcs_cmd_if.sink              cmd,
	hcs_report_if.source         report,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PERIOD_W-1:0]  cfg_data
);

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_STOP,
		ACT_TURN,
		ACT_BRAKE,
		ACT_SPEED
	} act_t;

	typedef struct packed {
		mode_t                        mode;
		logic                         dir;
		logic signed [PERMILLE_W-1:0] permille;
		logic [COUNT_W-1:0]           count;
		logic                         en;
		logic [PERIOD_W-1:0]          cmp_a;
		logic [PERIOD_W-1:0]          cmp_b;
	} rec_t;

	// ------------------------------------------------------------------
	// Configuration: PWM periods
	// ------------------------------------------------------------------
	logic [PERIOD_W-1:0] period_q [CFG_REG_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CFG_REG_COUNT; i++) begin
				period_q[i] <= PERIOD_RESET;
			end
		end else if (cfg_we) begin
			period_q[cfg_index] <= cfg_data;
		end
	end

	// ------------------------------------------------------------------
	// Input decode: fold the signed run into a plain run or stop
	// ------------------------------------------------------------------
	logic signed [16:0] sc_ext;
	logic [16:0]        sc_mag;
	logic [9:0]         sc_clip;
	logic [17:0]        sc_div;
	logic [7:0]         run_pct;
	op_t                op_in;
	logic [1:0]         dir_in;
	logic [7:0]         pd_in;

	always_comb begin
		sc_ext  = 17'(cmd.signed_command);
		sc_mag  = sc_ext[16] ? 17'(-sc_ext) : 17'(sc_ext);
		sc_clip = (sc_mag > 17'(CMD_LIMIT)) ? CMD_LIMIT : sc_mag[9:0];
		sc_div  = 18'(sc_clip) * 18'(DIV10_MUL);
		run_pct = 8'(sc_div[17:DIV10_SHIFT]);

		op_in  = cmd.op;
		dir_in = cmd.direction;
		pd_in  = cmd.percent;
		if (cmd.op == OP_RUN_SIGNED) begin
			if (cmd.signed_command == '0) begin
				op_in = OP_STOP_ONE;
			end else begin
				op_in  = OP_RUN_ONE;
				dir_in = sc_ext[16] ? DIR_B : DIR_A;
				pd_in  = run_pct;
			end
		end
	end

	// ------------------------------------------------------------------
	// Pipeline: s1 command, s2 duty * period, s3 compare value
	// ------------------------------------------------------------------
	logic valid_s1, valid_s2, valid_s3;
	logic adv_s1, adv_s2, adv_s3;
	logic commit;

	op_t        op_s1, op_s2, op_s3;
	logic [2:0] motor_s1, motor_s2, motor_s3;
	logic [1:0] dir_s1, dir_s2, dir_s3;
	logic [7:0] pd_s1, pd_s2, pd_s3;

	logic [6:0]          pclip_s1;
	logic [23:0]         prod_s2  [MOTOR_COUNT];
	logic [48:0]         scaled   [MOTOR_COUNT];
	logic [PERIOD_W-1:0] cmp_s3   [MOTOR_COUNT];

	assign adv_s3    = !valid_s3 || commit;
	assign adv_s2    = !valid_s2 || adv_s3;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign cmd.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= cmd.valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
		end
	end

	// Duty saturates at 100 percent for the compare value
	assign pclip_s1 = (pd_s1 > PCT_MAX) ? PCT_MAX[6:0] : pd_s1[6:0];

	always_comb begin
		for (int i = 0; i < MOTOR_COUNT; i++) begin
			scaled[i] = 49'(prod_s2[i]) * 49'(DIV100_MUL);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			op_s1    <= op_in;
			motor_s1 <= cmd.motor;
			dir_s1   <= dir_in;
			pd_s1    <= pd_in;
		end
		if (adv_s2) begin
			op_s2    <= op_s1;
			motor_s2 <= motor_s1;
			dir_s2   <= dir_s1;
			pd_s2    <= pd_s1;
			for (int i = 0; i < MOTOR_COUNT; i++) begin
				prod_s2[i] <= 24'(pclip_s1) * 24'(period_q[i]);
			end
		end
		if (adv_s3) begin
			op_s3    <= op_s2;
			motor_s3 <= motor_s2;
			dir_s3   <= dir_s2;
			pd_s3    <= pd_s2;
			for (int i = 0; i < MOTOR_COUNT; i++) begin
				cmp_s3[i] <= scaled[i][DIV100_SHIFT +: PERIOD_W];
			end
		end
	end

	// ------------------------------------------------------------------
	// Bridge state and commit of one command to every motor at once
	// ------------------------------------------------------------------
	logic               cdir_q     [MOTOR_COUNT];
	mode_t              pub_mode_q [MOTOR_COUNT];
	logic               pub_dir_q  [MOTOR_COUNT];
	logic [COUNT_W-1:0] count_q    [MOTOR_COUNT];

	act_t                  act      [MOTOR_COUNT];
	rec_t                  rec_d    [MOTOR_COUNT];
	logic                  cdir_d   [MOTOR_COUNT];
	logic [MOTOR_COUNT-1:0] new_mask;
	logic                  run_all_turn;
	logic [11:0]           pm10;

	assign pm10 = 12'({pd_s3, 3'b000}) + 12'({pd_s3, 1'b0});

	always_comb begin : commit_logic
		logic hit;
		logic differs;
		logic stop;
		logic drive;
		logic bump;

		// Run-all only reverses when some bridge points the other way
		run_all_turn = 1'b0;
		for (int i = 0; i < MOTOR_COUNT; i++) begin
			if (cdir_q[i] != dir_s3[0]) run_all_turn = 1'b1;
		end

		for (int i = 0; i < MOTOR_COUNT; i++) begin
			hit     = (motor_s3 == 3'(i));
			differs = (cdir_q[i] != dir_s3[0]);
			act[i]  = ACT_NONE;

			unique case (op_s3) inside
				OP_RUN_SIGNED, OP_RUN_ONE: begin
					if (hit) begin
						if (dir_s3[1])    act[i] = ACT_STOP;
						else if (differs) act[i] = ACT_TURN;
						else              act[i] = ACT_SPEED;
					end
				end
				OP_STOP_ONE: begin
					if (hit) act[i] = ACT_STOP;
				end
				OP_BRAKE_ONE: begin
					if (hit) act[i] = ACT_BRAKE;
				end
				OP_RUN_ALL: begin
					if (dir_s3[1])         act[i] = ACT_STOP;
					else if (run_all_turn) act[i] = differs ? ACT_TURN : ACT_NONE;
					else                   act[i] = ACT_SPEED;
				end
				OP_DIR_ALL: begin
					if (dir_s3[1])    act[i] = ACT_STOP;
					else if (differs) act[i] = ACT_TURN;
				end
				OP_SPEED_ALL: begin
					act[i] = ACT_SPEED;
				end
				OP_DISABLE_ALL: begin
					act[i] = ACT_STOP;
				end
				default: begin
					act[i] = ACT_NONE;
				end
			endcase

			// Zero duty on a speed request coasts the bridge
			stop  = (act[i] == ACT_STOP) || (act[i] == ACT_TURN) ||
			        ((act[i] == ACT_SPEED) && (pd_s3 == '0));
			drive = (act[i] == ACT_SPEED) && (pd_s3 != '0);

			if (stop)                      rec_d[i].mode = MODE_COAST;
			else if (act[i] == ACT_BRAKE)  rec_d[i].mode = MODE_BRAKE;
			else                           rec_d[i].mode = MODE_DRIVE;

			rec_d[i].dir   = cdir_q[i];
			rec_d[i].en    = !stop;
			rec_d[i].cmp_a = (drive && !cdir_q[i]) ? cmp_s3[i] : '0;
			rec_d[i].cmp_b = (drive &&  cdir_q[i]) ? cmp_s3[i] : '0;

			if (!drive)         rec_d[i].permille = '0;
			else if (cdir_q[i]) rec_d[i].permille = -$signed({1'b0, pm10});
			else                rec_d[i].permille =  $signed({1'b0, pm10});

			bump = (pub_mode_q[i] != rec_d[i].mode) || (pub_dir_q[i] != cdir_q[i]);
			rec_d[i].count = count_q[i] + COUNT_W'(bump);

			// A reversal stores the new direction after publishing the stop
			cdir_d[i]   = (act[i] == ACT_TURN) ? dir_s3[0] : cdir_q[i];
			new_mask[i] = valid_s3 && (act[i] != ACT_NONE);
		end
	end

	// ------------------------------------------------------------------
	// Report buffer: one entry per motor, drained lowest motor first
	// ------------------------------------------------------------------
	logic [MOTOR_COUNT-1:0] mask_q;
	logic [MOTOR_COUNT-1:0] low_bit;
	logic [MOTOR_COUNT-1:0] rest;
	logic                   buf_free;
	logic                   load;
	logic                   pop;
	rec_t                   rec_q [MOTOR_COUNT];

	assign low_bit  = mask_q & (~mask_q + MOTOR_COUNT'(1));
	assign rest     = mask_q & ~low_bit;
	assign pop      = report.valid && report.ready;
	assign buf_free = (mask_q == '0) || ((rest == '0) && report.ready);

	// A command with no report commits even while the buffer drains
	assign commit = valid_s3 && ((new_mask == '0) || buf_free);
	assign load   = commit && (new_mask != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			for (int i = 0; i < MOTOR_COUNT; i++) begin
				cdir_q[i]     <= 1'b0;
				pub_mode_q[i] <= MODE_COAST;
				pub_dir_q[i]  <= 1'b0;
				count_q[i]    <= '0;
			end
		end else begin
			if (load)     mask_q <= new_mask;
			else if (pop) mask_q <= rest;
			for (int i = 0; i < MOTOR_COUNT; i++) begin
				if (commit && new_mask[i]) begin
					cdir_q[i]     <= cdir_d[i];
					pub_mode_q[i] <= rec_d[i].mode;
					pub_dir_q[i]  <= rec_d[i].dir;
					count_q[i]    <= rec_d[i].count;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < MOTOR_COUNT; i++) begin
				rec_q[i] <= rec_d[i];
			end
		end
	end

	// Present the lowest pending motor
	always_comb begin
		report.valid             = (mask_q != '0);
		report.last              = (rest == '0);
		report.motor_index       = '0;
		report.mode              = MODE_COAST;
		report.applied_direction = 1'b0;
		report.applied_permille  = '0;
		report.transition_count  = '0;
		report.bridge_enable     = 1'b0;
		report.compare_a         = '0;
		report.compare_b         = '0;
		for (int i = 0; i < MOTOR_COUNT; i++) begin
			if (low_bit[i]) begin
				report.motor_index       = 3'(i);
				report.mode              = rec_q[i].mode;
				report.applied_direction = rec_q[i].dir;
				report.applied_permille  = rec_q[i].permille;
				report.transition_count  = rec_q[i].count;
				report.bridge_enable     = rec_q[i].en;
				report.compare_a         = rec_q[i].cmp_a;
				report.compare_b         = rec_q[i].cmp_b;
			end
		end
	end

endmodule

`default_nettype wire

[tb/hcs_report_check.sv]
`timescale 1ns / 1ps
// Report checker: predicts bridge state reports from accepted requests and compares them.
module hcs_report_check import hcs_pkg::*; #(
	parameter int MOTOR_COUNT = MOTOR_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	hcs_cmd_if                   cmd,
	hcs_report_if                report,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PERIOD_W-1:0]  cfg_data,
	output int                   fail_count,
	output int                   pending
);

	localparam int PERMILLE_PER_PERCENT = 10;

	typedef struct {
		logic [2:0]                   motor_index;
		mode_t                        mode;
		logic                         applied_direction;
		logic signed [PERMILLE_W-1:0] applied_permille;
		logic [COUNT_W-1:0]           transition_count;
		logic                         bridge_enable;
		logic [PERIOD_W-1:0]          compare_a;
		logic [PERIOD_W-1:0]          compare_b;
		logic                         last;
	} bridge_report_t;

	logic [PERIOD_W-1:0] period [CFG_REG_COUNT];
	logic                dir_cmd [MOTOR_COUNT];
	mode_t               mode_pub [MOTOR_COUNT];
	logic                dir_pub [MOTOR_COUNT];
	logic [COUNT_W-1:0]  changes [MOTOR_COUNT];
	logic                enabled [MOTOR_COUNT];
	logic [PERIOD_W-1:0] cmp_a [MOTOR_COUNT];
	logic [PERIOD_W-1:0] cmp_b [MOTOR_COUNT];
	bridge_report_t      expected_reports [$];
	int                  errors = 0;

	task automatic clear_bridges();
		for (int i = 0; i < CFG_REG_COUNT; i++)
			period[i] = PERIOD_RESET;
		for (int i = 0; i < MOTOR_COUNT; i++) begin
			dir_cmd[i]  = 1'b0;
			mode_pub[i] = MODE_COAST;
			dir_pub[i]  = 1'b0;
			changes[i]  = '0;
			enabled[i]  = 1'b0;
			cmp_a[i]    = '0;
			cmp_b[i]    = '0;
		end
		expected_reports.delete();
	endtask

	// Bump the count on a mode or direction change, then queue the report
	task automatic publish(int m, mode_t md, logic signed [PERMILLE_W-1:0] pm);
		bridge_report_t r;
		if (mode_pub[m] != md || dir_pub[m] != dir_cmd[m])
			changes[m] = changes[m] + 1'b1;
		mode_pub[m]         = md;
		dir_pub[m]          = dir_cmd[m];
		r.motor_index       = 3'(m);
		r.mode              = md;
		r.applied_direction = dir_cmd[m];
		r.applied_permille  = pm;
		r.transition_count  = changes[m];
		r.bridge_enable     = enabled[m];
		r.compare_a         = cmp_a[m];
		r.compare_b         = cmp_b[m];
		r.last              = 1'b0;
		expected_reports.push_back(r);
	endtask

	task automatic coast(int m);
		enabled[m] = 1'b0;
		cmp_a[m]   = '0;
		cmp_b[m]   = '0;
		publish(m, MODE_COAST, '0);
	endtask

	task automatic brake(int m);
		enabled[m] = 1'b1;
		cmp_a[m]   = '0;
		cmp_b[m]   = '0;
		publish(m, MODE_BRAKE, '0);
	endtask

	// Drive the channel of the commanded direction; zero duty coasts
	task automatic drive(int m, logic [7:0] pct);
		longint unsigned duty;
		longint unsigned level;
		int              mag;
		if (pct == 0) begin
			coast(m);
			return;
		end
		duty  = (pct > PCT_MAX) ? PCT_MAX : pct;
		level = duty * period[m] / PCT_MAX;
		mag   = int'(pct) * PERMILLE_PER_PERCENT;
		if (dir_cmd[m] == 1'b0) begin
			cmp_a[m] = PERIOD_W'(level);
			cmp_b[m] = '0;
		end else begin
			cmp_a[m] = '0;
			cmp_b[m] = PERIOD_W'(level);
			mag      = -mag;
		end
		enabled[m] = 1'b1;
		publish(m, MODE_DRIVE, PERMILLE_W'(mag));
	endtask

	// A reversal only stops the bridge and stores the new direction
	task automatic run_motor(int m, logic [1:0] dir, logic [7:0] pct);
		if (m >= MOTOR_COUNT)
			return;
		if (dir > DIR_B) begin
			coast(m);
		end else if (dir_cmd[m] != dir[0]) begin
			coast(m);
			dir_cmd[m] = dir[0];
		end else begin
			drive(m, pct);
		end
	endtask

	task automatic turn_all(logic [1:0] dir);
		for (int i = 0; i < MOTOR_COUNT; i++) begin
			if (dir > DIR_B) begin
				coast(i);
			end else if (dir_cmd[i] != dir[0]) begin
				coast(i);
				dir_cmd[i] = dir[0];
			end
		end
	endtask

	task automatic predict_request(op_t op, logic [2:0] motor, logic [1:0] dir,
			logic [7:0] pct, logic signed [15:0] command);
		int             first;
		int             m;
		int             clamped;
		bit             reversing;
		bridge_report_t r;
		first = expected_reports.size();
		m     = int'(motor);
		case (op)
			OP_RUN_SIGNED: begin
				clamped = int'(command);
				if (clamped > int'(CMD_LIMIT))
					clamped = int'(CMD_LIMIT);
				else if (clamped < -int'(CMD_LIMIT))
					clamped = -int'(CMD_LIMIT);
				if (clamped > 0)
					run_motor(m, DIR_A, 8'(clamped / PERMILLE_PER_PERCENT));
				else if (clamped < 0)
					run_motor(m, DIR_B, 8'(-clamped / PERMILLE_PER_PERCENT));
				else if (m < MOTOR_COUNT)
					coast(m);
			end
			OP_RUN_ONE: run_motor(m, dir, pct);
			OP_STOP_ONE: if (m < MOTOR_COUNT) coast(m);
			OP_BRAKE_ONE: if (m < MOTOR_COUNT) brake(m);
			OP_RUN_ALL: begin
				reversing = 1'b0;
				if (dir <= DIR_B)
					for (int i = 0; i < MOTOR_COUNT; i++)
						if (dir_cmd[i] != dir[0])
							reversing = 1'b1;
				if (dir > DIR_B || reversing) begin
					turn_all(dir);
				end else begin
					for (int i = 0; i < MOTOR_COUNT; i++)
						drive(i, pct);
				end
			end
			OP_DIR_ALL: turn_all(dir);
			OP_SPEED_ALL: begin
				for (int i = 0; i < MOTOR_COUNT; i++)
					drive(i, pct);
			end
			OP_DISABLE_ALL: begin
				for (int i = 0; i < MOTOR_COUNT; i++)
					coast(i);
			end
		endcase
		if (expected_reports.size() > first) begin
			r      = expected_reports.pop_back();
			r.last = 1'b1;
			expected_reports.push_back(r);
		end
	endtask

	function automatic int field_differs(string name, longint want, longint got);
		if (want == got)
			return 0;
		$display("%0t: report field %s mismatch, expected %0d, actual %0d",
			$time, name, want, got);
		return 1;
	endfunction

	task automatic check_report();
		bridge_report_t want;
		int             bad;
		if (expected_reports.size() == 0) begin
			$display("%0t: unexpected report, expected none, actual motor %0d mode %0d",
				$time, report.motor_index, report.mode);
			errors++;
			return;
		end
		want = expected_reports.pop_front();
		bad  = field_differs("motor_index", want.motor_index, report.motor_index)
			+ field_differs("mode", want.mode, report.mode)
			+ field_differs("applied_direction", want.applied_direction,
				report.applied_direction)
			+ field_differs("applied_permille", want.applied_permille,
				report.applied_permille)
			+ field_differs("transition_count", want.transition_count,
				report.transition_count)
			+ field_differs("bridge_enable", want.bridge_enable, report.bridge_enable)
			+ field_differs("compare_a", want.compare_a, report.compare_a)
			+ field_differs("compare_b", want.compare_b, report.compare_b)
			+ field_differs("last", want.last, report.last);
		if (bad != 0)
			errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_bridges();
			fail_count <= errors;
			pending    <= 0;
		end else begin
			if (cfg_we && int'(cfg_index) < CFG_REG_COUNT)
				period[cfg_index] = cfg_data;
			if (report.valid && report.ready)
				check_report();
			if (cmd.valid && cmd.ready)
				predict_request(cmd.op, cmd.motor, cmd.direction, cmd.percent,
					cmd.signed_command);
			fail_count <= errors;
			pending    <= expected_reports.size();
		end
	end

endmodule

[tb/hbridge_command_sequencer_tb.sv]
`timescale 1ns / 1ps
// Testbench top of the H-bridge command sequencer: clock, reset, stimulus and verdict.
module hbridge_command_sequencer_tb import hcs_pkg::*; ();

	localparam int CLK_PERIOD         = 8;
	localparam int RESET_CYCLES       = 9;
	localparam int PHASES             = 8;
	localparam int REQUESTS_PER_PHASE = 50;
	// Three front stages plus the report buffer, with margin
	localparam int SETTLE_CYCLES      = 10;
	localparam int LONG_HOLD          = 80;
	// Worst case: long gaps, four reports per request, each report stalled;
	// the limit is set well above that case
	localparam int LIMIT_CYCLES       = 400000;

	typedef struct {
		op_t                op;
		logic [2:0]         motor;
		logic [1:0]         direction;
		logic [7:0]         percent;
		logic signed [15:0] signed_command;
	} motor_request_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PERIOD_W-1:0]  cfg_data;
	int                   fail_count;
	int                   pending_reports;

	// calm: no idling on either side; hold_reports: one long receiver stall
	bit calm         = 1'b0;
	bit hold_reports = 1'b0;

	hcs_cmd_if    cmd ();
	hcs_report_if report ();

	hbridge_command_sequencer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.report    (report),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	hcs_report_check i_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.report     (report),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending_reports)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Hard stop in case a handshake never completes
	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("[FAIL] regression broken");
		$finish;
	end

	// Gap length once a side decides to idle: mostly short, a few long
	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic motor_request_t make_request(op_t op, int motor, int direction,
			int percent, int command);
		motor_request_t r;
		r.op             = op;
		r.motor          = 3'(motor);
		r.direction      = 2'(direction);
		r.percent        = 8'(percent);
		r.signed_command = 16'(command);
		return r;
	endfunction

	// Weight toward run commands so reversals get followed by drives;
	// keep some out-of-range motors and invalid directions as noise
	function automatic motor_request_t random_request();
		motor_request_t r;
		int             roll;
		roll = $urandom_range(0, 99);
		if (roll < 30)
			r.op = OP_RUN_ONE;
		else if (roll < 50)
			r.op = OP_RUN_SIGNED;
		else if (roll < 57)
			r.op = OP_STOP_ONE;
		else if (roll < 63)
			r.op = OP_BRAKE_ONE;
		else if (roll < 78)
			r.op = OP_RUN_ALL;
		else if (roll < 86)
			r.op = OP_DIR_ALL;
		else if (roll < 95)
			r.op = OP_SPEED_ALL;
		else
			r.op = OP_DISABLE_ALL;
		if ($urandom_range(0, 99) < 88)
			r.motor = 3'($urandom_range(0, MOTOR_COUNT_DEF - 1));
		else
			r.motor = 3'($urandom_range(MOTOR_COUNT_DEF, 7));
		if ($urandom_range(0, 99) < 85)
			r.direction = 2'($urandom_range(0, 1));
		else
			r.direction = 2'($urandom_range(2, 3));
		roll = $urandom_range(0, 99);
		if (roll < 8)
			r.percent = '0;
		else if (roll < 75)
			r.percent = 8'($urandom_range(1, 100));
		else
			r.percent = 8'($urandom_range(101, 255));
		roll = $urandom_range(0, 99);
		if (roll < 10)
			r.signed_command = '0;
		else if (roll < 80)
			r.signed_command = 16'(int'($urandom_range(0, 2400)) - 1200);
		else
			r.signed_command = 16'($urandom);
		return r;
	endfunction

	// Mostly plain periods, with the extremes and out-of-range values now and then
	function automatic logic [PERIOD_W-1:0] pick_period();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 12)
			return PERIOD_W'(1);
		if (roll < 24)
			return PERIOD_W'(65536);
		if (roll < 28)
			return '0;
		if (roll < 32)
			return '1;
		if (roll < 40)
			return PERIOD_RESET;
		return PERIOD_W'($urandom_range(1, 65536));
	endfunction

	// Offer one request, optionally after a gap, and hold it until taken
	task automatic send_request(motor_request_t r);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 99) < 35)
			gap = pick_gap();
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid          <= 1'b1;
		cmd.op             <= r.op;
		cmd.motor          <= r.motor;
		cmd.direction      <= r.direction;
		cmd.percent        <= r.percent;
		cmd.signed_command <= r.signed_command;
		do @(posedge clk); while (!cmd.ready);
	endtask

	// Drop valid, wait for every expected report, then let requests that
	// produce no report clear the pipeline
	task automatic wait_idle();
		cmd.valid <= 1'b0;
		@(posedge clk);
		while (pending_reports != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Back-to-back writes of all four periods; the first phase uses the extremes
	task automatic write_periods(int phase);
		logic [PERIOD_W-1:0] value;
		for (int i = 0; i < CFG_REG_COUNT; i++) begin
			if (phase == 0) begin
				case (i)
					0: value = '0;
					1: value = PERIOD_W'(1);
					2: value = PERIOD_W'(65536);
					default: value = '1;
				endcase
			end else begin
				value = pick_period();
			end
			cfg_we    <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data  <= value;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// Report side: ready in random bursts and gaps, or one long hold on request
	initial begin
		int span;
		report.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_reports) begin
				report.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_reports = 1'b0;
			end else if (calm || $urandom_range(0, 2) != 0) begin
				report.ready <= 1'b1;
				span = $urandom_range(1, 12);
				repeat (span) @(posedge clk);
			end else begin
				report.ready <= 1'b0;
				span = pick_gap();
				repeat (span) @(posedge clk);
			end
		end
	end

	initial begin
		motor_request_t prev;
		motor_request_t r;
		int             counted;

		arst_n             <= 1'b0;
		cmd.valid          <= 1'b0;
		cmd.op             <= OP_STOP_ONE;
		cmd.motor          <= '0;
		cmd.direction      <= DIR_A;
		cmd.percent        <= '0;
		cmd.signed_command <= '0;
		cfg_we             <= 1'b0;
		cfg_index          <= '0;
		cfg_data           <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed requests, all at the reset period
		send_request(make_request(OP_RUN_ONE, 0, DIR_A, 50, 0));
		// Duty above 100 saturates the compare but not the permille
		send_request(make_request(OP_RUN_ONE, 0, DIR_A, 255, 0));
		// Reversal: first stop, then drive on the repeat
		send_request(make_request(OP_RUN_ONE, 0, DIR_B, 30, 0));
		send_request(make_request(OP_RUN_ONE, 0, DIR_B, 30, 0));
		// Invalid direction and zero duty both stop
		send_request(make_request(OP_RUN_ONE, 1, 3, 80, 0));
		send_request(make_request(OP_RUN_ONE, 1, DIR_A, 0, 0));
		// Signed command clamped at both ends, then a reversal and a drive
		send_request(make_request(OP_RUN_SIGNED, 2, DIR_A, 0, 32767));
		send_request(make_request(OP_RUN_SIGNED, 2, DIR_A, 0, -32768));
		send_request(make_request(OP_RUN_SIGNED, 2, DIR_A, 0, -1000));
		send_request(make_request(OP_RUN_SIGNED, 3, DIR_A, 0, 0));
		// Below ten permille the duty rounds to zero and stops
		send_request(make_request(OP_RUN_SIGNED, 3, DIR_A, 0, 5));
		// Out-of-range motors are ignored; motor 1 is braked and stopped in between
		send_request(make_request(OP_RUN_SIGNED, 5, DIR_A, 0, 500));
		send_request(make_request(OP_STOP_ONE, 7, DIR_A, 0, 0));
		send_request(make_request(OP_BRAKE_ONE, 1, DIR_A, 0, 0));
		send_request(make_request(OP_BRAKE_ONE, 4, DIR_A, 0, 0));
		send_request(make_request(OP_STOP_ONE, 1, DIR_A, 0, 0));
		// Run all with motors pointing the other way only turns them; the repeat drives all, an invalid direction stops all
		send_request(make_request(OP_RUN_ALL, 0, DIR_A, 77, 0));
		send_request(make_request(OP_RUN_ALL, 0, DIR_A, 77, 0));
		send_request(make_request(OP_RUN_ALL, 0, 2, 77, 0));
		// Direction all with nothing to turn produces no report; then all turn, then all stop
		send_request(make_request(OP_DIR_ALL, 0, DIR_A, 0, 0));
		send_request(make_request(OP_DIR_ALL, 0, DIR_B, 0, 0));
		send_request(make_request(OP_DIR_ALL, 0, 3, 0, 0));
		send_request(make_request(OP_SPEED_ALL, 0, DIR_A, 100, 0));
		send_request(make_request(OP_SPEED_ALL, 0, DIR_A, 0, 0));
		send_request(make_request(OP_DISABLE_ALL, 0, DIR_A, 0, 0));

		prev = make_request(OP_DISABLE_ALL, 0, DIR_A, 0, 0);
		for (int p = 0; p < PHASES; p++) begin
			// Sender pauses here until every expected report has come
			wait_idle();
			write_periods(p);
			calm = (p == 2 || p == 3 || p == 5);
			// Stall the report side while requests keep coming
			if (p == 3)
				hold_reports = 1'b1;
			counted = 0;
			while (counted < REQUESTS_PER_PHASE) begin
				// Repeat the last request often so a reversal is followed by a drive
				if ($urandom_range(0, 99) < 30)
					r = prev;
				else
					r = random_request();
				send_request(r);
				prev = r;
				if (!(r.op inside {OP_RUN_SIGNED, OP_RUN_ONE, OP_STOP_ONE, OP_BRAKE_ONE}
						&& r.motor >= MOTOR_COUNT_DEF))
					counted++;
			end
		end
		calm = 1'b0;
		wait_idle();

		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
